// ===== hw/rtl/jse_pkg.sv =====
// Shared types, constants and escape helpers for the JSON string escaper.
package jse_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] LEAD2_MIN  = 8'hC2;
   localparam logic [7:0] LEAD2_MAX  = 8'hDF;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [7:0] LEAD3_MAX  = 8'hEF;
   localparam logic [7:0] LEAD4_MIN  = 8'hF0;
   localparam logic [7:0] LEAD4_MAX  = 8'hF4;
   localparam logic [7:0] ASCII_MAX  = 8'h7F;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   localparam logic [20:0] CP_MIN3    = 21'h000800;
   localparam logic [20:0] CP_MIN4    = 21'h010000;
   localparam logic [20:0] CP_SURR_LO = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
   localparam logic [20:0] CP_MAX     = 21'h10FFFF;

   localparam logic [1:0] SEQ_LEN2 = 2'd1;
   localparam logic [1:0] SEQ_LEN3 = 2'd2;
   localparam logic [1:0] SEQ_LEN4 = 2'd3;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_FF        = 8'h0C;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_RAW,
      ESC_SHORT,
      ESC_HEX
   } esc_kind_type;

   typedef struct packed {
      logic         err;
      logic         open_quote;
      esc_kind_type kind;
      logic [7:0]   data_byte;
      logic         close_quote;
   } entry_type;

   function automatic esc_kind_type classify(input logic [7:0] b);
      esc_kind_type k;
      case (b)
         CHAR_QUOTE, CHAR_BACKSLASH, CHAR_BS, CHAR_FF,
         CHAR_LF, CHAR_CR, CHAR_TAB: k = ESC_SHORT;
         default: k = (b < CTRL_LIMIT) ? ESC_HEX : ESC_RAW;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] esc_len(input esc_kind_type k);
      logic [2:0] n;
      case (k)
         ESC_RAW:   n = 3'd1;
         ESC_SHORT: n = 3'd2;
         ESC_HEX:   n = 3'd6;
         default:   n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] short_letter(input logic [7:0] b);
      logic [7:0] c;
      case (b)
         CHAR_BS:  c = CHAR_LOWER_B;
         CHAR_FF:  c = CHAR_LOWER_F;
         CHAR_LF:  c = CHAR_LOWER_N;
         CHAR_CR:  c = CHAR_LOWER_R;
         CHAR_TAB: c = CHAR_LOWER_T;
         default:  c = b;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] c;
      c = (v < 4'd10) ? (CHAR_ZERO + {4'd0, v}) : (CHAR_LOWER_A + {4'd0, v} - 8'd10);
      return c;
   endfunction

   function automatic logic [7:0] esc_char(input esc_kind_type k, input logic [7:0] b,
                                           input logic [2:0] j);
      logic [7:0] c;
      case (k)
         ESC_SHORT: c = (j == 3'd0) ? CHAR_BACKSLASH : short_letter(b);
         ESC_HEX: begin
            case (j)
               3'd0:    c = CHAR_BACKSLASH;
               3'd1:    c = CHAR_LOWER_U;
               3'd4:    c = hex_digit(b[7:4]);
               3'd5:    c = hex_digit(b[3:0]);
               default: c = CHAR_ZERO;
            endcase
         end
         default: c = b;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/jse_channels.sv =====
// Valid/ready channel interfaces for the request and response streams.
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_string;
   logic       empty_string;

   modport source(output valid, data_byte, end_of_string, empty_string, input ready);
   modport sink(input valid, data_byte, end_of_string, empty_string, output ready);
endinterface

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       string_done;
   logic       utf8_error;

   modport source(output valid, out_byte, run_last, string_done, utf8_error, input ready);
   modport sink(input valid, out_byte, run_last, string_done, utf8_error, output ready);
endinterface

// ===== hw/rtl/json_string_escaper_utf8_check.sv =====
// The first output character passes through the entry queue and then the output register.
// Throughput: one input byte per cycle while the entry queue is not full; an item expands to
//   1 to 8 output characters, the queue absorbing the difference.
// The front end stalls only when the entry queue is full.
// Reset: synchronous, clears decode state, queue pointers and output valid.
module json_string_escaper_utf8_check #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   jse_req_if.sink     req_chan,
   jse_rsp_if.source   rsp_chan
);
   import jse_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== hw/rtl/jse_front.sv =====
// Front end: accepts bytes, tracks UTF-8 decode state and classifies escapes.
module jse_front (
   input  logic                clock,
   input  logic                reset,
   jse_req_if.sink             req_chan,
   input  logic                queue_full,
   output logic                push,
   output jse_pkg::entry_type  push_entry
);
   import jse_pkg::*;

   logic        inside_ff, inside_in;
   logic [1:0]  pend_ff, pend_in;
   logic [1:0]  seq_ff, seq_in;
   logic [20:0] cp_ff, cp_in;
   logic        skip_ff, skip_in;

   logic        accept;
   logic        finishes;
   logic        ok;
   logic [7:0]  b;
   logic [1:0]  pend_dec;
   logic [20:0] cp_shift;
   logic [1:0]  pend_n;
   logic [1:0]  seq_n;
   logic [20:0] cp_n;

   assign req_chan.ready = !queue_full;
   assign accept   = req_chan.valid && req_chan.ready;
   assign finishes = req_chan.end_of_string || req_chan.empty_string;
   assign b        = req_chan.data_byte;
   assign pend_dec = pend_ff - 2'd1;
   assign cp_shift = {cp_ff[14:0], b[5:0]};

   always_comb begin
      ok     = 1'b1;
      pend_n = pend_ff;
      seq_n  = seq_ff;
      cp_n   = cp_ff;
      if (!req_chan.empty_string) begin
         if (pend_ff == 2'd0) begin
            if (b <= ASCII_MAX) begin
               ok = 1'b1;
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               pend_n = SEQ_LEN2;
               seq_n  = SEQ_LEN2;
               cp_n   = {16'd0, b[4:0]};
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               pend_n = SEQ_LEN3;
               seq_n  = SEQ_LEN3;
               cp_n   = {17'd0, b[3:0]};
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               pend_n = SEQ_LEN4;
               seq_n  = SEQ_LEN4;
               cp_n   = {18'd0, b[2:0]};
            end else begin
               ok = 1'b0;
            end
         end else if (b[7:6] != 2'b10) begin
            ok = 1'b0;
         end else begin
            cp_n   = cp_shift;
            pend_n = pend_dec;
            if (pend_dec == 2'd0) begin
               if (seq_ff == SEQ_LEN3 && cp_shift < CP_MIN3) ok = 1'b0;
               if (seq_ff == SEQ_LEN4 && cp_shift < CP_MIN4) ok = 1'b0;
               if (seq_ff == SEQ_LEN3 && cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI)
                  ok = 1'b0;
               if (cp_shift > CP_MAX) ok = 1'b0;
               if (ok) begin
                  seq_n = 2'd0;
                  cp_n  = 21'd0;
               end
            end
         end
      end
      if (finishes && pend_n != 2'd0) ok = 1'b0;
   end

   always_comb begin
      inside_in = inside_ff;
      pend_in   = pend_ff;
      seq_in    = seq_ff;
      cp_in     = cp_ff;
      skip_in   = skip_ff;
      push      = 1'b0;

      push_entry.err         = !ok;
      push_entry.open_quote  = !inside_ff;
      push_entry.kind        = req_chan.empty_string ? ESC_NONE : classify(b);
      push_entry.data_byte   = b;
      push_entry.close_quote = finishes;

      if (accept) begin
         if (!skip_ff) begin
            push = 1'b1;
         end
         if (finishes) begin
            inside_in = 1'b0;
            pend_in   = 2'd0;
            seq_in    = 2'd0;
            cp_in     = 21'd0;
            skip_in   = 1'b0;
         end else if (!skip_ff) begin
            if (!ok) begin
               skip_in = 1'b1;
            end else begin
               inside_in = 1'b1;
               pend_in   = pend_n;
               seq_in    = seq_n;
               cp_in     = cp_n;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         pend_ff   <= 2'd0;
         seq_ff    <= 2'd0;
         cp_ff     <= 21'd0;
         skip_ff   <= 1'b0;
      end else begin
         inside_ff <= inside_in;
         pend_ff   <= pend_in;
         seq_ff    <= seq_in;
         cp_ff     <= cp_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

// ===== hw/rtl/jse_queue.sv =====
// Short register queue of classified entries between front and back end.
module jse_queue #(
   parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jse_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output jse_pkg::entry_type  head_entry
);
   import jse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/jse_back.sv =====
// Back end: expands each entry into output characters through an output register.
module jse_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  jse_pkg::entry_type  head_entry,
   output logic                pop,
   jse_rsp_if.source           rsp_chan
);
   import jse_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       err_ff, err_in;

   logic [2:0] len;
   logic [3:0] total;
   logic [2:0] last_idx;
   logic [2:0] j;
   logic       load;

   assign len      = esc_len(head_entry.kind);
   assign total    = {3'd0, head_entry.open_quote} + {1'b0, len}
                     + {3'd0, head_entry.close_quote};
   assign last_idx = head_entry.err ? 3'd0 : 3'(total - 4'd1);
   assign j        = idx_ff - {2'd0, head_entry.open_quote};
   assign load     = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop      = load && (idx_ff == last_idx);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = (idx_ff == last_idx);
         done_in  = (idx_ff == last_idx) && (head_entry.close_quote || head_entry.err);
         err_in   = head_entry.err;
         if (head_entry.err) begin
            byte_in = 8'd0;
         end else if (head_entry.open_quote && idx_ff == 3'd0) begin
            byte_in = CHAR_QUOTE;
         end else if (j < len) begin
            byte_in = esc_char(head_entry.kind, head_entry.data_byte, j);
         end else begin
            byte_in = CHAR_QUOTE;
         end
         idx_in = (idx_ff == last_idx) ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
      err_ff  <= err_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.run_last    = last_ff;
   assign rsp_chan.string_done = done_ff;
   assign rsp_chan.utf8_error  = err_ff;

endmodule

// ===== hw/rtl/jse_checker.sv =====
// Port-level checks on the response stream, bound to the top level.
module jse_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       run_last,
   input logic       string_done,
   input logic       utf8_error
);
   import jse_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && utf8_error |-> run_last && string_done && out_byte == 8'd0)
      else $error("error transaction not a lone final marker");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && string_done |-> run_last)
      else $error("string end without item end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && string_done && !utf8_error |-> out_byte == CHAR_QUOTE)
      else $error("string end not a closing quote");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(run_last))
      else $error("stalled response transaction changed");

endmodule

bind json_string_escaper_utf8_check jse_checker u_jse_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .run_last    (rsp_chan.run_last),
   .string_done (rsp_chan.string_done),
   .utf8_error  (rsp_chan.utf8_error)
);

// ===== tb/jse_escape_checker.sv =====
// Checker for the JSON string escaper: predicts escaped output and compares it.
`timescale 1ns / 1ps

module jse_escape_checker (
   input  logic        clock,
   input  logic        reset,
   jse_req_if          req_mon,
   jse_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned chars_owed
);
   import jse_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       run_last;
      logic       string_done;
      logic       utf8_error;
   } out_char_type;

   out_char_type owed_q[$];

   logic        in_string;
   logic        skipping;
   logic [1:0]  cont_left;
   logic [1:0]  seq_len;
   logic [20:0] cp_acc;

   function automatic void clear_state();
      in_string = 1'b0;
      skipping  = 1'b0;
      cont_left = 2'd0;
      seq_len   = 2'd0;
      cp_acc    = 21'd0;
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("time %0t: %s", $time, msg);
   endfunction

   function automatic logic utf8_accept(input logic [7:0] b);
      logic [20:0] cp;
      if (cont_left == 2'd0) begin
         if (b <= ASCII_MAX) return 1'b1;
         if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
            cont_left = 2'd1;
            seq_len   = SEQ_LEN2;
            cp_acc    = {16'd0, b[4:0]};
         end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
            cont_left = 2'd2;
            seq_len   = SEQ_LEN3;
            cp_acc    = {17'd0, b[3:0]};
         end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
            cont_left = 2'd3;
            seq_len   = SEQ_LEN4;
            cp_acc    = {18'd0, b[2:0]};
         end else begin
            return 1'b0;
         end
         return 1'b1;
      end
      if (b[7:6] != 2'b10) return 1'b0;
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
         cp = cp_acc;
         if (seq_len == SEQ_LEN3 && cp < CP_MIN3) return 1'b0;
         if (seq_len == SEQ_LEN4 && cp < CP_MIN4) return 1'b0;
         if (seq_len == SEQ_LEN3 && cp >= CP_SURR_LO && cp <= CP_SURR_HI) return 1'b0;
         if (cp > CP_MAX) return 1'b0;
         seq_len = 2'd0;
         cp_acc  = 21'd0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_escape(input logic [7:0] b, input logic eos,
                                          input logic emp);
      logic [7:0] chars[$];
      logic [7:0] letter;
      string      hexd;
      logic       fin;
      logic       ok;
      hexd = "0123456789abcdef";
      fin  = eos | emp;
      if (skipping) begin
         if (fin) clear_state();
         return;
      end
      ok = 1'b1;
      if (!emp) ok = utf8_accept(b);
      if (ok && fin && cont_left != 2'd0) ok = 1'b0;
      if (!ok) begin
         owed_q.push_back('{8'h00, 1'b1, 1'b1, 1'b1});
         if (fin) clear_state();
         else skipping = 1'b1;
         return;
      end
      if (!in_string) begin
         chars.push_back(CHAR_QUOTE);
         in_string = 1'b1;
      end
      if (!emp) begin
         case (b)
            CHAR_QUOTE, CHAR_BACKSLASH: letter = b;
            CHAR_BS:  letter = CHAR_LOWER_B;
            CHAR_FF:  letter = CHAR_LOWER_F;
            CHAR_LF:  letter = CHAR_LOWER_N;
            CHAR_CR:  letter = CHAR_LOWER_R;
            CHAR_TAB: letter = CHAR_LOWER_T;
            default:  letter = 8'h00;
         endcase
         if (letter != 8'h00) begin
            chars.push_back(CHAR_BACKSLASH);
            chars.push_back(letter);
         end else if (b < CTRL_LIMIT) begin
            chars.push_back(CHAR_BACKSLASH);
            chars.push_back(CHAR_LOWER_U);
            chars.push_back(CHAR_ZERO);
            chars.push_back(CHAR_ZERO);
            chars.push_back(hexd[b[7:4]]);
            chars.push_back(hexd[b[3:0]]);
         end else begin
            chars.push_back(b);
         end
      end
      if (fin) chars.push_back(CHAR_QUOTE);
      foreach (chars[i]) begin
         owed_q.push_back('{chars[i], i == chars.size() - 1,
                            fin && (i == chars.size() - 1), 1'b0});
      end
      if (fin) clear_state();
   endfunction

   always @(posedge clock) begin : watch
      out_char_type got;
      out_char_type want;
      logic [10:0]  care;
      if (reset) begin
         clear_state();
         owed_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            predict_escape(req_mon.data_byte, req_mon.end_of_string, req_mon.empty_string);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.out_byte, rsp_mon.run_last, rsp_mon.string_done,
                    rsp_mon.utf8_error};
            if (owed_q.size() == 0) begin
               note_failure($sformatf("unexpected character %02h last=%b done=%b err=%b",
                                      got.ch, got.run_last, got.string_done, got.utf8_error));
            end else begin
               want = owed_q.pop_front();
               care = want.utf8_error ? 11'h007 : 11'h7FF;
               if (((got ^ want) & care) != 11'h000) begin
                  note_failure($sformatf(
                     "expected %02h last=%b done=%b err=%b, got %02h last=%b done=%b err=%b",
                     want.ch, want.run_last, want.string_done, want.utf8_error,
                     got.ch, got.run_last, got.string_done, got.utf8_error));
               end
            end
         end
      end
      chars_owed <= owed_q.size();
   end

endmodule

// ===== tb/json_string_escaper_utf8_check_tb.sv =====
// Top of the JSON string escaper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module json_string_escaper_utf8_check_tb;
   import jse_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned PHASE_ITEMS   = 35;

   typedef struct {
      logic [7:0] b;
      logic       eos;
      logic       emp;
   } req_item_type;

   logic         clock = 1'b0;
   logic         reset;
   int unsigned  send_idle_pct;
   int unsigned  stall_pct;
   int unsigned  cycle_count = 0;
   int unsigned  mismatches;
   int unsigned  owed;
   req_item_type stim_q[$];

   jse_req_if req_if();
   jse_rsp_if rsp_if();

   json_string_escaper_utf8_check i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   jse_escape_checker i_escape_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatches),
      .chars_owed     (owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_item(input logic [7:0] b, input logic eos, input logic emp);
      stim_q.push_back('{b, eos, emp});
   endtask

   task automatic push_char(input int unsigned cp, input int nbytes, input int flaw);
      logic [7:0] seq[4];
      int         n;
      int         k;
      n = nbytes;
      case (nbytes)
         2: begin
            seq[0] = 8'(32'hC0 | (cp >> 6));
            seq[1] = 8'(32'h80 | (cp & 32'h3F));
         end
         3: begin
            seq[0] = 8'(32'hE0 | (cp >> 12));
            seq[1] = 8'(32'h80 | ((cp >> 6) & 32'h3F));
            seq[2] = 8'(32'h80 | (cp & 32'h3F));
         end
         default: begin
            seq[0] = 8'(32'hF0 | (cp >> 18));
            seq[1] = 8'(32'h80 | ((cp >> 12) & 32'h3F));
            seq[2] = 8'(32'h80 | ((cp >> 6) & 32'h3F));
            seq[3] = 8'(32'h80 | (cp & 32'h3F));
         end
      endcase
      if (flaw == 1) begin
         k = $urandom_range(n - 1, 1);
         seq[k] = 8'($urandom);
         if (seq[k][7:6] == 2'b10) seq[k][6] = 1'b1;
      end else if (flaw == 2) begin
         n = $urandom_range(n - 1, 1);
      end
      for (k = 0; k < n; k++) push_item(seq[k], 1'b0, 1'b0);
   endtask

   task automatic add_random_string();
      int unsigned len;
      int unsigned r;
      int unsigned cp;
      int          start;
      bit          cut;
      start = stim_q.size();
      len   = $urandom_range(8, 0);
      cut   = 1'b0;
      for (int i = 0; i < len && !cut; i++) begin
         r = $urandom_range(99);
         if (r < 35) begin
            push_item(8'($urandom_range(8'h7E, 8'h20)), 1'b0, 1'b0);
         end else if (r < 50) begin
            cp = $urandom_range(34, 0);
            case (cp)
               32:      push_item(CHAR_QUOTE, 1'b0, 1'b0);
               33:      push_item(CHAR_BACKSLASH, 1'b0, 1'b0);
               34:      push_item(ASCII_MAX, 1'b0, 1'b0);
               default: push_item(8'(cp), 1'b0, 1'b0);
            endcase
         end else if (r < 62) begin
            push_char($urandom_range(32'h7FF, 32'h80), 2, 0);
         end else if (r < 74) begin
            cp = $urandom_range(32'hFFFF, 32'h800);
            if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp ^ 32'h1000;
            push_char(cp, 3, 0);
         end else if (r < 84) begin
            push_char($urandom_range(32'h10FFFF, 32'h10000), 4, 0);
         end else if (r < 88) begin
            push_char($urandom_range(32'h7FF, 0), 3, 0);
         end else if (r < 91) begin
            push_char($urandom_range(32'hDFFF, 32'hD800), 3, 0);
         end else if (r < 93) begin
            push_char($urandom_range(32'hFFFF, 0), 4, 0);
         end else if (r < 95) begin
            push_char($urandom_range(32'h1FFFFF, 32'h110000), 4, 0);
         end else if (r < 98) begin
            cp = $urandom_range(2, 1);
            push_char($urandom_range(32'hFFFF, 32'hE000), 3, cp);
            cut = (cp == 2);
         end else begin
            push_item(8'($urandom_range(8'hFF, 8'h80)), 1'b0, 1'b0);
         end
      end
      if (stim_q.size() == start || $urandom_range(99) < 12) begin
         push_item(8'($urandom), 1'($urandom), 1'b1);
      end else begin
         stim_q[stim_q.size() - 1].eos = 1'b1;
      end
   endtask

   task automatic load_directed();
      push_item(8'hA5, 1'b0, 1'b1);
      push_item(CHAR_QUOTE, 1'b0, 1'b0);
      push_item(CHAR_BACKSLASH, 1'b0, 1'b0);
      push_item(CHAR_BS, 1'b0, 1'b0);
      push_item(CHAR_FF, 1'b0, 1'b0);
      push_item(CHAR_LF, 1'b0, 1'b0);
      push_item(CHAR_CR, 1'b0, 1'b0);
      push_item(CHAR_TAB, 1'b0, 1'b0);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'h1F, 1'b0, 1'b0);
      push_item(ASCII_MAX, 1'b1, 1'b0);
      push_item(LEAD2_MIN, 1'b0, 1'b0);
      push_item(8'h80, 1'b0, 1'b0);
      push_item(LEAD4_MAX, 1'b0, 1'b0);
      push_item(8'h8F, 1'b0, 1'b0);
      push_item(8'hBF, 1'b0, 1'b0);
      push_item(8'hBF, 1'b1, 1'b0);
      push_item(LEAD3_MIN, 1'b0, 1'b0);
      push_item(8'h80, 1'b0, 1'b0);
      push_item(8'h80, 1'b1, 1'b0);
      push_item(LEAD2_MIN, 1'b0, 1'b0);
      push_item(8'h5A, 1'b0, 1'b1);
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h41, 1'b1, 1'b0);
      push_item(8'hE1, 1'b1, 1'b0);
   endtask

   task automatic send_txn(input req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid     <= 1'b0;
         req_if.data_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.data_byte     <= it.b;
      req_if.end_of_string <= it.eos;
      req_if.empty_string  <= it.emp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic play_items();
      while (stim_q.size() != 0) send_txn(stim_q.pop_front());
   endtask

   // hold off until every owed character has come back
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_if.valid         <= 1'b0;
      req_if.data_byte     <= 8'h00;
      req_if.end_of_string <= 1'b0;
      req_if.empty_string  <= 1'b0;
      reset                <= 1'b1;
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      load_directed();
      play_items();
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 75; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         while (stim_q.size() < PHASE_ITEMS) add_random_string();
         play_items();
         settle();
      end

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
